@@ design/nrtc_pkg.sv @@
// nrtc_pkg: word types, function codes, register map and timer constants
// for the nibble real-time-clock register file; no dependencies
`default_nettype none

package nrtc_pkg;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] reg_addr;
      logic [3:0] write_nibble;
      logic [5:0] now_seconds;
      logic [5:0] now_minutes;
      logic [4:0] now_hours;
      logic [4:0] now_day_of_month;
      logic [2:0] now_weekday;
      logic [3:0] now_month;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_pending;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] units;
   } bcd_pair_type;

   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [3:0] REG_TEST       = 4'd0;
   localparam logic [3:0] REG_TENTHS     = 4'd1;
   localparam logic [3:0] REG_SEC_UNITS  = 4'd2;
   localparam logic [3:0] REG_SEC_TENS   = 4'd3;
   localparam logic [3:0] REG_MIN_UNITS  = 4'd4;
   localparam logic [3:0] REG_MIN_TENS   = 4'd5;
   localparam logic [3:0] REG_HOUR_UNITS = 4'd6;
   localparam logic [3:0] REG_HOUR_TENS  = 4'd7;
   localparam logic [3:0] REG_DAY_UNITS  = 4'd8;
   localparam logic [3:0] REG_DAY_TENS   = 4'd9;
   localparam logic [3:0] REG_WEEKDAY    = 4'd10;
   localparam logic [3:0] REG_MON_UNITS  = 4'd11;
   localparam logic [3:0] REG_MON_TENS   = 4'd12;
   localparam logic [3:0] REG_YEAR       = 4'd13;
   localparam logic [3:0] REG_ZERO       = 4'd14;
   localparam logic [3:0] REG_MODE       = 4'd15;

   localparam logic [2:0] PERIOD_60S   = 3'd4;
   localparam logic [2:0] PERIOD_5S    = 3'd2;
   localparam logic [2:0] PERIOD_500MS = 3'd1;

   localparam logic [12:0] COUNT_60S   = 13'd6000;
   localparam logic [12:0] COUNT_5S    = 13'd500;
   localparam logic [12:0] COUNT_500MS = 13'd50;

   localparam logic [7:0] READ_ALL_ONES = 8'hFF;
   localparam logic [3:0] TENTHS_LAST   = 4'd9;

   // split a 6-bit value into tens and units
   function automatic bcd_pair_type bcd_split(input logic [5:0] value);
      bcd_pair_type pair;
      logic [6:0]   tens_x10;
      if (value >= 6'd60) begin
         pair.tens = 4'd6;
      end else if (value >= 6'd50) begin
         pair.tens = 4'd5;
      end else if (value >= 6'd40) begin
         pair.tens = 4'd4;
      end else if (value >= 6'd30) begin
         pair.tens = 4'd3;
      end else if (value >= 6'd20) begin
         pair.tens = 4'd2;
      end else if (value >= 6'd10) begin
         pair.tens = 4'd1;
      end else begin
         pair.tens = 4'd0;
      end
      tens_x10   = {pair.tens[2:0], 3'b000} + {2'b00, pair.tens[2:0], 1'b0};
      pair.units = 4'(({1'b0, value} - tens_x10));
      return pair;
   endfunction

endpackage

`default_nettype wire

@@ design/nibble_rtc_interrupt_timer.sv @@
// nibble_rtc_interrupt_timer: nibble-wide rtc register file with periodic
// interrupt timer; depends on nrtc_pkg
//
// usage:
//   req channel (req_valid, req_stall, req_data) carries one word per item:
//   a register read, a register write or a 100 Hz tick, together with the
//   current time of day from the outside clock
//   rsp channel (rsp_valid, rsp_stall, rsp_data) returns one word per item:
//   the read value (0 for writes and ticks) and the pending flag after it
//   a word is taken at a rising edge with valid high and stall low
//   a word passes through the input register and the result register;
//   throughput one item per cycle while rsp_stall is low, set by the single
//   update of the mode, pending, count and tenths registers between the two
//   reset clears the mode, pending flag, tick count, tenths counter and both
//   valid flags
//   when rsp_stall holds a waiting result, the input register still takes one
//   more word, then req_stall rises until the result is taken
`default_nettype none

module nibble_rtc_interrupt_timer (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  nrtc_pkg::req_word_type    req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output nrtc_pkg::rsp_word_type    rsp_data
);

   logic                   in_valid_ff, in_valid_in;
   nrtc_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff, out_valid_in;
   nrtc_pkg::rsp_word_type out_word_ff, out_word_in;

   logic [3:0]  mode_ff, mode_in;
   logic        pending_ff, pending_in;
   logic [12:0] count_ff, count_in;
   logic [3:0]  tenths_ff, tenths_in;

   logic req_fire, advance, process;
   logic [7:0] read_value;
   logic [4:0] month_one;
   nrtc_pkg::bcd_pair_type sec_bcd, min_bcd, hour_bcd, day_bcd, mon_bcd;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;
   assign process   = in_valid_ff && advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   assign month_one = {1'b0, in_word_ff.now_month} + 5'd1;
   assign sec_bcd   = nrtc_pkg::bcd_split(in_word_ff.now_seconds);
   assign min_bcd   = nrtc_pkg::bcd_split(in_word_ff.now_minutes);
   assign hour_bcd  = nrtc_pkg::bcd_split({1'b0, in_word_ff.now_hours});
   assign day_bcd   = nrtc_pkg::bcd_split({1'b0, in_word_ff.now_day_of_month});
   assign mon_bcd   = nrtc_pkg::bcd_split({1'b0, month_one});

   always_comb begin
      logic [12:0] reload_value;
      logic [12:0] count_dec;

      mode_in     = mode_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      tenths_in   = tenths_ff;
      read_value  = 8'd0;
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = process ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
      count_dec   = count_ff - 13'd1;

      // reload value for the mode that will be in force
      case (in_word_ff.func == nrtc_pkg::FUNC_WRITE ?
            in_word_ff.write_nibble[2:0] : mode_ff[2:0])
         nrtc_pkg::PERIOD_60S:   reload_value = nrtc_pkg::COUNT_60S;
         nrtc_pkg::PERIOD_5S:    reload_value = nrtc_pkg::COUNT_5S;
         nrtc_pkg::PERIOD_500MS: reload_value = nrtc_pkg::COUNT_500MS;
         default:                reload_value = count_ff;
      endcase

      if (process) begin
         case (in_word_ff.func)
            nrtc_pkg::FUNC_READ: begin
               case (in_word_ff.reg_addr)
                  nrtc_pkg::REG_TEST:       read_value = nrtc_pkg::READ_ALL_ONES;
                  nrtc_pkg::REG_TENTHS: begin
                     read_value = {4'd0, tenths_ff};
                     tenths_in  = (tenths_ff >= nrtc_pkg::TENTHS_LAST) ?
                                  4'd0 : tenths_ff + 4'd1;
                  end
                  nrtc_pkg::REG_SEC_UNITS:  read_value = {4'd0, sec_bcd.units};
                  nrtc_pkg::REG_SEC_TENS:   read_value = {4'd0, sec_bcd.tens};
                  nrtc_pkg::REG_MIN_UNITS:  read_value = {4'd0, min_bcd.units};
                  nrtc_pkg::REG_MIN_TENS:   read_value = {4'd0, min_bcd.tens};
                  nrtc_pkg::REG_HOUR_UNITS: read_value = {4'd0, hour_bcd.units};
                  nrtc_pkg::REG_HOUR_TENS:  read_value = {4'd0, hour_bcd.tens};
                  nrtc_pkg::REG_DAY_UNITS:  read_value = {4'd0, day_bcd.units};
                  nrtc_pkg::REG_DAY_TENS:   read_value = {4'd0, day_bcd.tens};
                  nrtc_pkg::REG_WEEKDAY:
                     read_value = {5'd0, in_word_ff.now_weekday} + 8'd1;
                  nrtc_pkg::REG_MON_UNITS:  read_value = {4'd0, mon_bcd.units};
                  nrtc_pkg::REG_MON_TENS:   read_value = {4'd0, mon_bcd.tens};
                  nrtc_pkg::REG_YEAR:       read_value = nrtc_pkg::READ_ALL_ONES;
                  nrtc_pkg::REG_ZERO:       read_value = 8'd0;
                  default: begin
                     // mode register: read acknowledges the interrupt
                     read_value = {4'd0, mode_ff};
                     pending_in = 1'b0;
                     if (mode_ff[3]) begin
                        count_in = reload_value;
                     end
                  end
               endcase
            end
            nrtc_pkg::FUNC_WRITE: begin
               if (in_word_ff.reg_addr == nrtc_pkg::REG_MODE) begin
                  mode_in    = in_word_ff.write_nibble;
                  pending_in = 1'b0;
                  count_in   = reload_value;
               end
            end
            nrtc_pkg::FUNC_TICK: begin
               if (mode_ff[2:0] != 3'd0 && count_ff != 13'd0) begin
                  count_in = count_dec;
                  if (count_dec == 13'd0) begin
                     pending_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      out_word_in.read_data   = read_value;
      out_word_in.irq_pending = pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 4'd0;
         pending_ff   <= 1'b0;
         count_ff     <= 13'd0;
         tenths_ff    <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         tenths_ff    <= tenths_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_data;
      end
      if (process) begin
         out_word_ff <= out_word_in;
      end
   end

   // tick count stays within the longest period
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nrtc_pkg::COUNT_60S)
      else $error("tick count above longest period");

   // tenths counter wraps at nine
   a_tenths_range: assert property (@(posedge clock) disable iff (reset)
      tenths_ff <= nrtc_pkg::TENTHS_LAST)
      else $error("tenths counter out of range");

   // pending rises only on a tick that ends the count
   a_pending_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff) |-> $past(process && in_word_ff.func == nrtc_pkg::FUNC_TICK
                                  && count_ff == 13'd1))
      else $error("pending raised without expiring tick");

   // a new result reports the pending flag it leaves behind
   a_rsp_pending: assert property (@(posedge clock) disable iff (reset)
      process |=> (rsp_valid && rsp_data.irq_pending == pending_ff))
      else $error("result pending flag mismatch");

   // input is held off only with a word waiting in the input register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked word");

endmodule

`default_nettype wire
